[hdl/kld_sample_size_calculator_unit_macros.svh]
// Assertion macros for the KLD sample size calculator.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef KLD_SAMPLE_SIZE_CALCULATOR_UNIT_MACROS_SVH
`define KLD_SAMPLE_SIZE_CALCULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define KLD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/kld_pkg.sv]
// Shared types and constants of the KLD sample size calculator.
// No dependencies; used by kld_ctrl, kld_dp and the top level.
`default_nettype none
package kld_pkg;

  localparam int X_BINS_DEF     = 32;
  localparam int Y_BINS_DEF     = 32;
  localparam int THETA_BINS_DEF = 16;
  localparam int TAG_BITS_DEF   = 8;

  localparam int BIN_W   = 8;
  localparam int COUNT_W = 15;
  localparam int NEED_W  = 20;
  localparam int STEP_W  = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 15'h7fff;
  localparam logic [NEED_W-1:0]  NEEDED_MAX = 20'hfffff;

  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  localparam logic [STEP_W-1:0] MUL_LAST  = 6'd4;
  localparam logic [STEP_W-1:0] DIV_LAST  = 6'd33;
  localparam logic [STEP_W-1:0] SQRT_LAST = 6'd31;

  // configuration register indexes
  localparam logic [2:0] CFG_INV_X    = 3'd0;
  localparam logic [2:0] CFG_INV_Y    = 3'd1;
  localparam logic [2:0] CFG_INV_T    = 3'd2;
  localparam logic [2:0] CFG_Z        = 3'd3;
  localparam logic [2:0] CFG_INV_2EPS = 3'd4;
  localparam logic [2:0] CFG_MIN      = 3'd5;

  // datapath operations
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NOP      = 4'd0;
  localparam dp_op_t OP_CLR      = 4'd1;
  localparam dp_op_t OP_LOAD     = 4'd2;
  localparam dp_op_t OP_START    = 4'd3;
  localparam dp_op_t OP_MUL_LOAD = 4'd4;
  localparam dp_op_t OP_MUL_STEP = 4'd5;
  localparam dp_op_t OP_MUL_USE  = 4'd6;
  localparam dp_op_t OP_RD       = 4'd7;
  localparam dp_op_t OP_CMP      = 4'd8;
  localparam dp_op_t OP_RAW0     = 4'd9;
  localparam dp_op_t OP_DIV_INIT = 4'd10;
  localparam dp_op_t OP_DIV_STEP = 4'd11;
  localparam dp_op_t OP_SQ_INIT  = 4'd12;
  localparam dp_op_t OP_SQ_STEP  = 4'd13;
  localparam dp_op_t OP_OUT      = 4'd14;

  // which product the shared multiplier forms
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MS_X    = 3'd0;
  localparam mul_sel_t MS_Y    = 3'd1;
  localparam mul_sel_t MS_T    = 3'd2;
  localparam mul_sel_t MS_ZS   = 3'd3;
  localparam mul_sel_t MS_SQ   = 3'd4;
  localparam mul_sel_t MS_CU   = 3'd5;
  localparam mul_sel_t MS_COEF = 3'd6;
  localparam mul_sel_t MS_FIN  = 3'd7;

  typedef struct packed {
    dp_op_t              op;
    mul_sel_t            sel;
    logic [STEP_W-1:0]   step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic tag_full;
    logic fresh;
    logic k_gt1;
    logic clr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/kld_ctrl.sv]
// Controller of the KLD sample size calculator: sequences the datapath.
// Depends on kld_pkg and kld_sample_size_calculator_unit_macros.svh.
`default_nettype none
`include "kld_sample_size_calculator_unit_macros.svh"
module kld_ctrl
  import kld_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_MLOAD = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_MEND  = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_BND   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_SQI   = 4'd10;
  localparam logic [3:0] S_SQRT  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  mul_sel_t          sel_r, sel_nxt;
  logic              after_clr_r, after_clr_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    after_clr_nxt = after_clr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = OP_NOP;
    cmd.sel       = sel_r;
    cmd.step      = cnt_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) begin
          state_nxt     = after_clr_r ? S_DONE : S_IDLE;
          after_clr_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_start) begin
          cmd.op = OP_START;
          if (stat.tag_full) begin
            after_clr_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.op    = OP_MUL_LOAD;
          cmd.sel   = MS_X;
          sel_nxt   = MS_X;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MLOAD: begin
        cmd.op    = OP_MUL_LOAD;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op  = OP_MUL_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_MEND;
        end
      end
      S_MEND: begin
        cmd.op    = OP_MUL_USE;
        state_nxt = S_MLOAD;
        case (sel_r)
          MS_X:    sel_nxt = MS_Y;
          MS_Y:    sel_nxt = MS_T;
          MS_T:    state_nxt = S_RD;
          MS_ZS:   sel_nxt = MS_SQ;
          MS_SQ:   sel_nxt = MS_CU;
          MS_CU:   sel_nxt = MS_COEF;
          MS_COEF: sel_nxt = MS_FIN;
          default: state_nxt = S_DONE;
        endcase
      end
      S_RD: begin
        cmd.op    = OP_RD;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = stat.fresh ? S_BND : S_DONE;
      end
      S_BND: begin
        if (stat.k_gt1) begin
          cmd.op    = OP_DIV_INIT;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cmd.op    = OP_RAW0;
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.op    = OP_SQ_INIT;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQ_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) begin
          sel_nxt   = MS_ZS;
          state_nxt = S_MLOAD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      sel_r       <= MS_X;
      after_clr_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      after_clr_r <= after_clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `KLD_ASSERT_NEXT(a_accept_drops_ready, in_tvalid && in_tready, !in_tready, "ready after accept")
  `KLD_ASSERT_NOW(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE, "stray result")
  `KLD_ASSERT_NOW(a_mul_count, state_r == S_MUL, cnt_r <= MUL_LAST, "multiplier step overrun")
  `KLD_ASSERT_NEXT(a_clear_exit, state_r == S_CLEAR && stat.clr_last,
                   state_r == S_IDLE || state_r == S_DONE, "clear pass exit")

endmodule
`default_nettype wire

[hdl/kld_dp.sv]
// Datapath: config registers, binning, tag store, shared multiplier, divider, square root.
// Depends on kld_pkg; driven by kld_ctrl commands.
`default_nettype none
module kld_dp
  import kld_pkg::*;
#(
  parameter int X_BINS     = X_BINS_DEF,
  parameter int Y_BINS     = Y_BINS_DEF,
  parameter int THETA_BINS = THETA_BINS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic [103:0] in_tdata,
  input  wire logic        in_tuser,
  output logic [39:0]      out_tdata,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat
);

  localparam int DEPTH = X_BINS * Y_BINS * THETA_BINS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int YT    = Y_BINS * THETA_BINS;
  localparam logic [BIN_W:0] X_HALF = (BIN_W+1)'(X_BINS / 2);
  localparam logic [BIN_W:0] X_TOP  = (BIN_W+1)'(X_BINS - 1);
  localparam logic [BIN_W:0] Y_HALF = (BIN_W+1)'(Y_BINS / 2);
  localparam logic [BIN_W:0] Y_TOP  = (BIN_W+1)'(Y_BINS - 1);
  localparam logic [BIN_W:0] T_HALF = (BIN_W+1)'(THETA_BINS / 2);
  localparam logic [BIN_W:0] T_TOP  = (BIN_W+1)'(THETA_BINS - 1);

  // q: truncated magnitude quotient; rnz: fraction bits nonzero
  function automatic logic [BIN_W-1:0] clamp_bin(input logic [35:0] q, input logic rnz,
      input logic neg, input logic [BIN_W:0] half, input logic [BIN_W:0] top);
    logic [36:0] qq;
    logic [36:0] b;
    qq = {1'b0, q} + {36'b0, rnz};
    if (neg) begin
      if (qq > {28'b0, half}) b = '0;
      else b = {28'b0, half} - qq;
    end else begin
      if ({1'b0, q} > {28'b0, top - half}) b = {28'b0, top};
      else b = {1'b0, q} + {28'b0, half};
    end
    return b[BIN_W-1:0];
  endfunction

  // configuration
  logic [31:0] inv_x_r, inv_y_r, inv_t_r, inv2e_r;
  logic [15:0] z_r;
  logic [19:0] min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_x_r <= 32'd655360;
      inv_y_r <= 32'd655360;
      inv_t_r <= 32'd655360;
      z_r     <= 16'd9464;
      inv2e_r <= 32'd655360;
      min_r   <= 20'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_X:    inv_x_r <= cfg_wdata;
        CFG_INV_Y:    inv_y_r <= cfg_wdata;
        CFG_INV_T:    inv_t_r <= cfg_wdata;
        CFG_Z:        z_r     <= cfg_wdata[15:0];
        CFG_INV_2EPS: inv2e_r <= cfg_wdata;
        CFG_MIN:      min_r   <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // item and state registers
  logic              op_r;
  logic [31:0]       px_r, py_r, cx_r, cy_r;
  logic [15:0]       pt_r, ct_r;
  logic [19:0]       drawn_r;
  logic [TAG_BITS-1:0] tag_r, rd_r;
  logic [COUNT_W-1:0] count_r;
  logic [NEED_W-1:0] raw_r;
  logic              fresh_r;
  logic [63:0]       ma_r, mb_r, pp_r;
  logic [1:0]        ppsh_r;
  logic [127:0]      acc_r;
  logic              neg_r;
  logic [BIN_W-1:0]  bx_r, by_r, bt_r;
  logic [IDX_W-1:0]  idx_r, clr_r;
  logic [19:0]       drem_r;
  logic [33:0]       dq_r;
  logic [63:0]       sv_r, sr_r;
  logic [31:0]       inner_r;
  logic [39:0]       sq_r, cube_r;
  logic [47:0]       coef_r;
  logic              out_new_r, out_enough_r;
  logic [COUNT_W-1:0] out_cnt_r;
  logic [NEED_W-1:0] out_need_r;

  logic [TAG_BITS-1:0] tag_mem [DEPTH];

  // combinational helpers
  logic [32:0]  dx, dy;
  logic [17:0]  dt0, dt;
  logic [63:0]  ld_a, ld_b;
  logic         ld_neg;
  logic [31:0]  a_part, b_part;
  logic [127:0] pp_ext;
  logic [COUNT_W-1:0] m;
  logic [18:0]  dvs;
  logic [20:0]  dtrial;
  logic [5:0]   sq_sh;
  logic [63:0]  sq_bit, sq_trial;
  logic [39:0]  inner_pre;
  logic [24:0]  idx_full;
  logic [IDX_W-1:0] idx_w;
  logic         fresh;
  logic         mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [TAG_BITS-1:0] mem_wd;

  assign dx  = {px_r[31], px_r} - {cx_r[31], cx_r};
  assign dy  = {py_r[31], py_r} - {cy_r[31], cy_r};
  assign dt0 = {{2{pt_r[15]}}, pt_r} - {{2{ct_r[15]}}, ct_r};

  // heading difference folded once into [-pi, pi)
  always_comb begin
    if ($signed(dt0) >= PI_Q13) dt = dt0 - TWO_PI_Q13;
    else if ($signed(dt0) < -PI_Q13) dt = dt0 + TWO_PI_Q13;
    else dt = dt0;
  end

  assign m   = count_r - 1'b1;
  assign dvs = 19'(m) * 19'd9;

  always_comb begin
    ld_neg = 1'b0;
    ld_a   = '0;
    ld_b   = '0;
    case (cmd.sel)
      MS_X: begin
        ld_neg = dx[32];
        ld_a   = {32'b0, dx[32] ? 32'(-dx) : dx[31:0]};
        ld_b   = {32'b0, inv_x_r};
      end
      MS_Y: begin
        ld_neg = dy[32];
        ld_a   = {32'b0, dy[32] ? 32'(-dy) : dy[31:0]};
        ld_b   = {32'b0, inv_y_r};
      end
      MS_T: begin
        ld_neg = dt[17];
        ld_a   = {46'b0, dt[17] ? 18'(-dt) : dt};
        ld_b   = {32'b0, inv_t_r};
      end
      MS_ZS: begin
        ld_a = {48'b0, z_r};
        ld_b = {32'b0, sr_r[31:0]};
      end
      MS_SQ: begin
        ld_a = {32'b0, inner_r};
        ld_b = {32'b0, inner_r};
      end
      MS_CU: begin
        ld_a = {24'b0, sq_r};
        ld_b = {32'b0, inner_r};
      end
      MS_COEF: begin
        ld_a = {49'b0, m};
        ld_b = {32'b0, inv2e_r};
      end
      MS_FIN: begin
        ld_a = {16'b0, coef_r};
        ld_b = {24'b0, cube_r};
      end
      default: ;
    endcase
  end

  // partial product order: a0b0, a0b1, a1b0, a1b1
  assign a_part = cmd.step[1] ? ma_r[63:32] : ma_r[31:0];
  assign b_part = cmd.step[0] ? mb_r[63:32] : mb_r[31:0];

  always_comb begin
    case (ppsh_r)
      2'd0:    pp_ext = {64'b0, pp_r};
      2'd1:    pp_ext = {32'b0, pp_r, 32'b0};
      default: pp_ext = {pp_r, 64'b0};
    endcase
  end

  assign dtrial    = {drem_r, (cmd.step == '0)};
  assign sq_sh     = 6'd62 - {cmd.step[4:0], 1'b0};
  assign sq_bit    = 64'd1 << sq_sh;
  assign sq_trial  = sr_r + sq_bit;
  assign inner_pre = 40'h01_0000_0000 - {8'b0, dq_r[31:0]} + acc_r[51:12];

  assign idx_full = 25'(bx_r) * 25'(YT) + 25'(by_r) * 25'(THETA_BINS) + 25'(bt_r);
  assign idx_w    = idx_full[IDX_W-1:0];
  assign fresh    = (rd_r != tag_r);

  assign mem_we = (cmd.op == OP_CLR) || ((cmd.op == OP_CMP) && fresh);
  assign mem_wa = (cmd.op == OP_CLR) ? clr_r : idx_r;
  assign mem_wd = (cmd.op == OP_CLR) ? '0 : tag_r;

  always_ff @(posedge clk) begin
    if (mem_we) tag_mem[mem_wa] <= mem_wd;
    rd_r <= tag_mem[idx_w];
  end

  assign stat.is_start = !op_r;
  assign stat.tag_full = &tag_r;
  assign stat.fresh    = fresh;
  assign stat.k_gt1    = (count_r > 15'd1);
  assign stat.clr_last = (clr_r == IDX_W'(DEPTH - 1));

  // control-like state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      count_r <= '0;
      raw_r   <= '0;
      cx_r    <= '0;
      cy_r    <= '0;
      ct_r    <= '0;
      clr_r   <= '0;
      fresh_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CLR:   clr_r <= stat.clr_last ? '0 : clr_r + 1'b1;
        OP_LOAD:  fresh_r <= 1'b0;
        OP_START: begin
          cx_r    <= px_r;
          cy_r    <= py_r;
          ct_r    <= pt_r;
          count_r <= '0;
          raw_r   <= '0;
          tag_r   <= (&tag_r) ? TAG_BITS'(1) : tag_r + 1'b1;
        end
        OP_CMP: begin
          if (fresh) begin
            fresh_r <= 1'b1;
            if (count_r != COUNT_MAX) count_r <= count_r + 1'b1;
          end
        end
        OP_RAW0: raw_r <= '0;
        OP_MUL_USE: begin
          if (cmd.sel == MS_FIN) raw_r <= (|acc_r[127:60]) ? NEEDED_MAX : acc_r[59:40];
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        op_r    <= in_tuser;
        px_r    <= in_tdata[31:0];
        py_r    <= in_tdata[63:32];
        pt_r    <= in_tdata[79:64];
        drawn_r <= in_tdata[99:80];
      end
      OP_MUL_LOAD: begin
        ma_r  <= ld_a;
        mb_r  <= ld_b;
        neg_r <= ld_neg;
      end
      OP_MUL_STEP: begin
        if (cmd.step != MUL_LAST) begin
          pp_r   <= 64'(a_part) * 64'(b_part);
          ppsh_r <= 2'(cmd.step[1]) + 2'(cmd.step[0]);
        end
        if (cmd.step == '0) acc_r <= '0;
        else acc_r <= acc_r + pp_ext;
      end
      OP_MUL_USE: begin
        case (cmd.sel)
          MS_X:    bx_r <= clamp_bin({4'b0, acc_r[63:32]}, |acc_r[31:0], neg_r, X_HALF, X_TOP);
          MS_Y:    by_r <= clamp_bin({4'b0, acc_r[63:32]}, |acc_r[31:0], neg_r, Y_HALF, Y_TOP);
          MS_T:    bt_r <= clamp_bin({1'b0, acc_r[63:29]}, |acc_r[28:0], neg_r, T_HALF, T_TOP);
          MS_ZS:   inner_r <= inner_pre[39:8];
          MS_SQ:   sq_r <= acc_r[63:24];
          MS_CU:   cube_r <= acc_r[63:24];
          MS_COEF: coef_r <= acc_r[47:0];
          default: ;
        endcase
      end
      OP_RD: idx_r <= idx_w;
      OP_DIV_INIT: begin
        drem_r <= '0;
        dq_r   <= '0;
      end
      OP_DIV_STEP: begin
        if (dtrial >= {2'b0, dvs}) begin
          drem_r <= 20'(dtrial - {2'b0, dvs});
          dq_r   <= {dq_r[32:0], 1'b1};
        end else begin
          drem_r <= dtrial[19:0];
          dq_r   <= {dq_r[32:0], 1'b0};
        end
      end
      OP_SQ_INIT: begin
        sv_r <= {dq_r[31:0], 32'b0};
        sr_r <= '0;
      end
      OP_SQ_STEP: begin
        if (sv_r >= sq_trial) begin
          sv_r <= sv_r - sq_trial;
          sr_r <= (sr_r >> 1) + sq_bit;
        end else begin
          sr_r <= sr_r >> 1;
        end
      end
      OP_OUT: begin
        out_new_r    <= fresh_r;
        out_cnt_r    <= count_r;
        out_need_r   <= (raw_r < min_r) ? min_r : raw_r;
        out_enough_r <= (drawn_r >= raw_r) && (drawn_r > min_r);
      end
      default: ;
    endcase
  end

  assign out_tdata = {3'b0, out_enough_r, out_need_r, out_cnt_r, out_new_r};

endmodule
`default_nettype wire

[hdl/kld_sample_size_calculator_unit.sv]
// KLD sample size calculator. One item in flight: the sample path runs three
// shared-multiplier passes, and a new bin, once more than one bin is filled, adds
// the 34-step divider, the 32-step square root and five more multiplier passes.
// Reset is synchronous active low; after reset, and when the epoch tag wraps on a
// start beat, a clearing pass over all X_BINS*Y_BINS*THETA_BINS tag entries (16384 by
// default) runs.
`default_nettype none
module kld_sample_size_calculator_unit
  import kld_pkg::*;
#(
  parameter int X_BINS     = X_BINS_DEF,
  parameter int Y_BINS     = Y_BINS_DEF,
  parameter int THETA_BINS = THETA_BINS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration writes: index selects the register, no read-back
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata,
  // input beats
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,   // pose_x, pose_y, pose_theta, num_drawn, zero pad
  input  wire logic         in_tuser,   // op: 0 start, 1 sample
  // result beats
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [39:0]       out_tdata   // new_bin, filled_bins, samples_needed, enough_drawn, pad
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: sequencing, handshakes and the result valid flag
  kld_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // datapath: binning, epoch-tagged occupancy store, KLD bound arithmetic
  kld_dp #(
    .X_BINS     (X_BINS),
    .Y_BINS     (Y_BINS),
    .THETA_BINS (THETA_BINS),
    .TAG_BITS   (TAG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire
